### hdl/csem_pkg.sv
`timescale 1ns / 1ps
// Package for the counting semaphore table: opcodes, status codes, the
// command kinds passed from the front end to the back end, and shared widths.
// No dependencies.
package csem_pkg;

   localparam int ID_BITS     = 7;
   localparam int INIT_BITS   = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic LEVEL_SYSTEM = 1'b1;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_WAIT   = 2'd1,
      OP_SIGNAL = 2'd2,
      OP_UNUSED = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_BAD_ID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_ALLOC  = 2'd0,
      KIND_WAIT   = 2'd1,
      KIND_SIGNAL = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      status_type          status;
      logic [ID_BITS-1:0]  new_id;
   } cmd_info_type;

endpackage

### hdl/counting_semaphore_table_unit.sv
`timescale 1ns / 1ps
// Top level of the counting semaphore table: front end, command queue,
// back end and counter RAM. Depends on csem_pkg and all csem_* modules.
//
// A request is taken at a rising edge where start is high and busy is low;
// every request yields exactly one result, shown for one cycle with
// rsp_strobe high. The receiver cannot stall, so results are never held.
// The front end checks the id or hands out the next id of the caller's
// half in the cycle of the transfer and places the command in a two-entry
// queue; busy is high only while that queue is full. The back end takes one
// command from the queue at a time: an allocate or a rejected request is
// finished in BK_IDLE as it is popped, with its result registered at that
// edge; a wait or signal reads its counter word as it is popped, then in
// BK_MODIFY does the modify and write-back through the single counter RAM
// port pair and registers its result. The back end takes no new command
// while a wait or signal is in BK_MODIFY; allocates and rejects can be
// taken back to back. Results come back in request order. Counters are held
// in a RAM of 2*SEMS_PER_LEVEL words that is never cleared; only allocated
// ids can reach it, and allocation writes the word first.
module counting_semaphore_table_unit #(
   parameter int SEMS_PER_LEVEL = 64,
   parameter int COUNT_BITS     = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_opcode,
   input  logic                                  req_caller_level,
   input  logic [csem_pkg::ID_BITS-1:0]          req_sem_id,
   input  logic signed [csem_pkg::INIT_BITS-1:0] req_initial_count,
   output logic                                  rsp_strobe,
   output logic [1:0]                            rsp_status,
   output logic [csem_pkg::ID_BITS-1:0]          rsp_new_id,
   output logic                                  rsp_must_block,
   output logic                                  rsp_wake_one
);

   import csem_pkg::*;

   localparam int TABLE_SIZE = 2 * SEMS_PER_LEVEL;
   localparam int AW         = $clog2(TABLE_SIZE);
   localparam int QW         = $bits(cmd_info_type) + AW + COUNT_BITS;

   // Front end to queue.
   logic                  push;
   cmd_info_type          push_info;
   logic [AW-1:0]         push_addr;
   logic [COUNT_BITS-1:0] push_count;
   logic                  q_full;
   logic                  q_empty;
   logic                  q_pop;
   logic [QW-1:0]         q_head;
   cmd_info_type          q_info;
   logic [AW-1:0]         q_addr;
   logic [COUNT_BITS-1:0] q_count;

   // Back end to counter RAM.
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [COUNT_BITS-1:0] ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [COUNT_BITS-1:0] ram_rdata;

   csem_front #(
      .SEMS_PER_LEVEL (SEMS_PER_LEVEL),
      .COUNT_BITS     (COUNT_BITS),
      .AW             (AW)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .queue_full        (q_full),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_caller_level  (req_caller_level),
      .req_sem_id        (req_sem_id),
      .req_initial_count (req_initial_count),
      .push              (push),
      .push_info         (push_info),
      .push_addr         (push_addr),
      .push_count        (push_count)
   );

   csem_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_info, push_addr, push_count}),
      .pop       (q_pop),
      .pop_data  (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   assign {q_info, q_addr, q_count} = q_head;

   csem_back #(
      .COUNT_BITS (COUNT_BITS),
      .AW         (AW)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_info         (q_info),
      .q_addr         (q_addr),
      .q_count        (q_count),
      .q_pop          (q_pop),
      .ram_we         (ram_we),
      .ram_waddr      (ram_waddr),
      .ram_wdata      (ram_wdata),
      .ram_raddr      (ram_raddr),
      .ram_rdata      (ram_rdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_new_id     (rsp_new_id),
      .rsp_must_block (rsp_must_block),
      .rsp_wake_one   (rsp_wake_one)
   );

   csem_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (TABLE_SIZE)
   ) u_counters (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // An accepted request always leaves a command waiting in the queue.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !q_empty)
      else $error("accepted transfer did not reach the command queue");

   // Every counter write belongs to exactly one result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |=> rsp_strobe)
      else $error("counter write without a result");

   // A failed request reports no id and no scheduling hint.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |->
         (rsp_new_id == '0) && !rsp_must_block && !rsp_wake_one)
      else $error("failed request carries result flags");

   // Block and wake come from different operations.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_must_block && rsp_wake_one))
      else $error("block and wake reported together");

endmodule

### hdl/csem_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module csem_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/csem_queue.sv
`timescale 1ns / 1ps
// Small register FIFO that carries classified commands from front to back end.
// No package dependencies; DEPTH must be a power of two.
module csem_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/csem_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, checks ids, hands out new ids and saturates
// the initial count. Depends on csem_pkg.
module csem_front #(
   parameter int SEMS_PER_LEVEL = 64,
   parameter int COUNT_BITS     = 16,
   parameter int AW             = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               queue_full,
   output logic                               busy,
   input  logic [1:0]                         req_opcode,
   input  logic                               req_caller_level,
   input  logic [csem_pkg::ID_BITS-1:0]       req_sem_id,
   input  logic signed [csem_pkg::INIT_BITS-1:0] req_initial_count,
   output logic                               push,
   output csem_pkg::cmd_info_type             push_info,
   output logic [AW-1:0]                      push_addr,
   output logic [COUNT_BITS-1:0]              push_count
);

   import csem_pkg::*;

   localparam int CW = $clog2(SEMS_PER_LEVEL + 1);
   localparam logic [CW-1:0] LEVEL_SIZE = CW'(SEMS_PER_LEVEL);
   localparam logic signed [32:0] CNT_MAX = (33'sd1 <<< (COUNT_BITS - 1)) - 33'sd1;
   localparam logic signed [32:0] CNT_MIN = -CNT_MAX - 33'sd1;

   logic [CW-1:0]      user_cnt_ff, user_cnt_in;
   logic [CW-1:0]      sys_cnt_ff, sys_cnt_in;
   logic               accept;
   logic [31:0]        id_wide;
   logic [31:0]        slot;
   logic               id_ok;
   logic signed [32:0] init_wide;
   logic signed [32:0] init_sat;
   opcode_type         op;

   assign accept = start && !queue_full;
   assign busy   = queue_full;
   assign push   = accept;

   always_comb begin
      op          = opcode_type'(req_opcode);
      id_wide     = 32'(req_sem_id);
      slot        = id_wide;
      user_cnt_in = user_cnt_ff;
      sys_cnt_in  = sys_cnt_ff;
      id_ok       = (id_wide < 32'(user_cnt_ff)) ||
                    ((req_caller_level == LEVEL_SYSTEM) &&
                     (id_wide >= 32'(SEMS_PER_LEVEL)) &&
                     ((id_wide - 32'(SEMS_PER_LEVEL)) < 32'(sys_cnt_ff)));
      push_info.kind   = KIND_REJECT;
      push_info.status = STATUS_BAD_ID;
      push_info.new_id = '0;
      case (op)
         OP_ALLOC: begin
            if (req_caller_level != LEVEL_SYSTEM) begin
               if (user_cnt_ff < LEVEL_SIZE) begin
                  slot             = 32'(user_cnt_ff);
                  push_info.kind   = KIND_ALLOC;
                  push_info.status = STATUS_OK;
                  user_cnt_in      = accept ? user_cnt_ff + CW'(1) : user_cnt_ff;
               end else begin
                  push_info.status = STATUS_FULL;
               end
            end else begin
               if (sys_cnt_ff < LEVEL_SIZE) begin
                  slot             = 32'(SEMS_PER_LEVEL) + 32'(sys_cnt_ff);
                  push_info.kind   = KIND_ALLOC;
                  push_info.status = STATUS_OK;
                  sys_cnt_in       = accept ? sys_cnt_ff + CW'(1) : sys_cnt_ff;
               end else begin
                  push_info.status = STATUS_FULL;
               end
            end
            if (push_info.kind == KIND_ALLOC) begin
               push_info.new_id = slot[ID_BITS-1:0];
            end
         end
         OP_WAIT: begin
            if (id_ok) begin
               push_info.kind   = KIND_WAIT;
               push_info.status = STATUS_OK;
            end
         end
         OP_SIGNAL: begin
            if (id_ok) begin
               push_info.kind   = KIND_SIGNAL;
               push_info.status = STATUS_OK;
            end
         end
         default: begin
            push_info.kind   = KIND_REJECT;
            push_info.status = STATUS_BAD_ID;
         end
      endcase
      push_addr = slot[AW-1:0];
   end

   // Saturate the 16-bit initial count into the counter range.
   always_comb begin
      init_wide = 33'(req_initial_count);
      if (init_wide > CNT_MAX) begin
         init_sat = CNT_MAX;
      end else if (init_wide < CNT_MIN) begin
         init_sat = CNT_MIN;
      end else begin
         init_sat = init_wide;
      end
      push_count = init_sat[COUNT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         user_cnt_ff <= '0;
         sys_cnt_ff  <= '0;
      end else begin
         user_cnt_ff <= user_cnt_in;
         sys_cnt_ff  <= sys_cnt_in;
      end
   end

endmodule

### hdl/csem_back.sv
`timescale 1ns / 1ps
// Back end: executes queued commands against the counter RAM and registers
// the result. Depends on csem_pkg.
module csem_back #(
   parameter int COUNT_BITS = 16,
   parameter int AW         = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  csem_pkg::cmd_info_type        q_info,
   input  logic [AW-1:0]                 q_addr,
   input  logic [COUNT_BITS-1:0]         q_count,
   output logic                          q_pop,
   output logic                          ram_we,
   output logic [AW-1:0]                 ram_waddr,
   output logic [COUNT_BITS-1:0]         ram_wdata,
   output logic [AW-1:0]                 ram_raddr,
   input  logic [COUNT_BITS-1:0]         ram_rdata,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status,
   output logic [csem_pkg::ID_BITS-1:0]  rsp_new_id,
   output logic                          rsp_must_block,
   output logic                          rsp_wake_one
);

   import csem_pkg::*;

   typedef enum logic [1:0] {
      BK_IDLE   = 2'b01,
      BK_MODIFY = 2'b10
   } back_state_type;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS - 1){1'b1}}};
   localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS - 1){1'b0}}};

   back_state_type         state_ff, state_in;
   kind_type               kind_ff, kind_in;
   logic [AW-1:0]          addr_ff, addr_in;
   logic                   strobe_ff, strobe_in;
   status_type             status_ff, status_in;
   logic [ID_BITS-1:0]     new_id_ff, new_id_in;
   logic                   block_ff, block_in;
   logic                   wake_ff, wake_in;
   logic [COUNT_BITS-1:0]  next_count;

   assign ram_raddr = q_addr;

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      addr_in    = addr_ff;
      strobe_in  = 1'b0;
      status_in  = status_ff;
      new_id_in  = new_id_ff;
      block_in   = block_ff;
      wake_in    = wake_ff;
      q_pop      = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = q_addr;
      ram_wdata  = q_count;
      next_count = ram_rdata;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               kind_in = q_info.kind;
               addr_in = q_addr;
               case (q_info.kind)
                  KIND_WAIT, KIND_SIGNAL: begin
                     // The counter word is read at this edge and modified next cycle.
                     state_in = BK_MODIFY;
                  end
                  KIND_ALLOC: begin
                     ram_we    = 1'b1;
                     strobe_in = 1'b1;
                     status_in = STATUS_OK;
                     new_id_in = q_info.new_id;
                     block_in  = 1'b0;
                     wake_in   = 1'b0;
                  end
                  default: begin
                     strobe_in = 1'b1;
                     status_in = q_info.status;
                     new_id_in = '0;
                     block_in  = 1'b0;
                     wake_in   = 1'b0;
                  end
               endcase
            end
         end
         BK_MODIFY: begin
            block_in = 1'b0;
            wake_in  = 1'b0;
            if (kind_ff == KIND_WAIT) begin
               if (ram_rdata != CNT_MIN) begin
                  next_count = ram_rdata - COUNT_BITS'(1);
               end
               block_in = next_count[COUNT_BITS-1];
            end else begin
               if (ram_rdata != CNT_MAX) begin
                  next_count = ram_rdata + COUNT_BITS'(1);
               end
               wake_in = next_count[COUNT_BITS-1] || (next_count == '0);
            end
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            ram_wdata = next_count;
            strobe_in = 1'b1;
            status_in = STATUS_OK;
            new_id_in = '0;
            state_in  = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      addr_ff   <= addr_in;
      status_ff <= status_in;
      new_id_ff <= new_id_in;
      block_ff  <= block_in;
      wake_ff   <= wake_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = status_ff;
   assign rsp_new_id     = new_id_ff;
   assign rsp_must_block = block_ff;
   assign rsp_wake_one   = wake_ff;

endmodule

### dv/tb_counting_semaphore_table_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for counting_semaphore_table_unit: a directed opening, random
// traffic under several sender idling mixes, and a predictor of the semaphore table.
// Depends on csem_pkg and the RTL of the block.
module tb_counting_semaphore_table_unit;
   import csem_pkg::*;

   // The table is built with its default sizes: 64 semaphores per half, 16-bit counters.
   localparam int SEMS_PER_LEVEL = 64;
   localparam int TABLE_WORDS    = 2 * SEMS_PER_LEVEL;
   localparam logic signed [INIT_BITS-1:0] COUNT_MAX = 16'sh7FFF;
   localparam logic signed [INIT_BITS-1:0] COUNT_MIN = 16'sh8000;
   localparam logic signed [INIT_BITS-1:0] COUNT_ONE = 16'sd1;
   localparam int STALL_LIMIT    = 2000;
   localparam int PRINT_LIMIT    = 40;
   localparam int RANDOM_ITEMS   = 170;

   typedef struct {
      opcode_type                   op;
      logic                         level;
      logic [ID_BITS-1:0]           id;
      logic signed [INIT_BITS-1:0]  init;
   } sem_request_type;

   typedef struct {
      status_type                   status;
      logic [ID_BITS-1:0]           new_id;
      logic                         must_block;
      logic                         wake_one;
   } sem_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]                    req_opcode        = '0;
   logic                          req_caller_level  = 1'b0;
   logic [ID_BITS-1:0]            req_sem_id        = '0;
   logic signed [INIT_BITS-1:0]   req_initial_count = '0;
   logic                          rsp_strobe;
   logic [1:0]                    rsp_status;
   logic [ID_BITS-1:0]            rsp_new_id;
   logic                          rsp_must_block;
   logic                          rsp_wake_one;

   counting_semaphore_table_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_caller_level  (req_caller_level),
      .req_sem_id        (req_sem_id),
      .req_initial_count (req_initial_count),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_new_id        (rsp_new_id),
      .rsp_must_block    (rsp_must_block),
      .rsp_wake_one      (rsp_wake_one)
   );

   always #5 clock = ~clock;

   // Requests waiting to be driven, and the results still owed by the block in order.
   sem_request_type pending_requests[$];
   sem_result_type  owed_results[$];

   // Predictor state: the counters and how many ids each half has handed out.
   logic signed [INIT_BITS-1:0] token_count [TABLE_WORDS];
   int user_granted   = 0;
   int system_granted = 0;

   // The stimulus side keeps its own allocation counts so that it can aim waits and
   // signals at ids that are live. They follow the same rule as the predictor.
   int gen_user_count   = 0;
   int gen_system_count = 0;

   int  sender_idle_pct = 0;
   logic req_taken      = 1'b0;
   int  stall_cycles    = 0;
   int  mismatch_count  = 0;
   int  requests_taken  = 0;
   int  grants_seen = 0, full_seen = 0, bad_seen = 0, blocks_seen = 0, wakes_seen = 0;

   task automatic report_mismatch(string field, int got, int want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      mismatch_count++;
   endtask

   // Only ids below the user count are open to everybody. A system caller may also use
   // the allocated part of the upper half.
   function automatic bit id_usable(int id, logic level);
      if (id < user_granted)
         return 1'b1;
      return level == LEVEL_SYSTEM && id >= SEMS_PER_LEVEL &&
             id - SEMS_PER_LEVEL < system_granted;
   endfunction

   function automatic sem_result_type predict_semaphore_op(sem_request_type rq);
      sem_result_type res;
      logic signed [INIT_BITS-1:0] tokens;
      int slot;
      res.status     = STATUS_OK;
      res.new_id     = '0;
      res.must_block = 1'b0;
      res.wake_one   = 1'b0;
      slot           = -1;
      case (rq.op)
         OP_ALLOC: begin
            if (rq.level == LEVEL_SYSTEM) begin
               if (system_granted < SEMS_PER_LEVEL) begin
                  slot = SEMS_PER_LEVEL + system_granted;
                  system_granted++;
               end
            end else if (user_granted < SEMS_PER_LEVEL) begin
               slot = user_granted;
               user_granted++;
            end
            if (slot < 0) begin
               res.status = STATUS_FULL;
            end else begin
               token_count[slot] = rq.init;
               res.new_id = slot[ID_BITS-1:0];
            end
         end
         OP_WAIT, OP_SIGNAL: begin
            if (!id_usable(int'(rq.id), rq.level)) begin
               res.status = STATUS_BAD_ID;
            end else begin
               tokens = token_count[rq.id];
               // Both directions stick at the counter limits instead of wrapping.
               if (rq.op == OP_WAIT) begin
                  if (tokens != COUNT_MIN)
                     tokens = tokens - COUNT_ONE;
                  res.must_block = tokens < 0;
               end else begin
                  if (tokens != COUNT_MAX)
                     tokens = tokens + COUNT_ONE;
                  res.wake_one = tokens <= 0;
               end
               token_count[rq.id] = tokens;
            end
         end
         default: res.status = STATUS_BAD_ID;
      endcase
      return res;
   endfunction

   task automatic push_request(opcode_type op, logic level, int id, int init);
      sem_request_type rq;
      rq.op    = op;
      rq.level = level;
      rq.id    = id[ID_BITS-1:0];
      rq.init  = init[INIT_BITS-1:0];
      if (op == OP_ALLOC) begin
         if (level == LEVEL_SYSTEM && gen_system_count < SEMS_PER_LEVEL)
            gen_system_count++;
         else if (level != LEVEL_SYSTEM && gen_user_count < SEMS_PER_LEVEL)
            gen_user_count++;
      end
      pending_requests.push_back(rq);
   endtask

   // Half the counts sit near zero so that waits and signals cross it often; the rest are
   // at or next to the limits, or fully random words.
   function automatic int random_count();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50)
         return $urandom_range(8) - 4;
      if (pick < 75) begin
         case ($urandom_range(3))
            0: return 32767;
            1: return -32768;
            2: return 32766;
            default: return -32767;
         endcase
      end
      return $urandom_range(65535);
   endfunction

   task automatic queue_random_request();
      int pick, total;
      logic level;
      opcode_type op;
      int id;
      pick  = $urandom_range(99);
      level = 1'($urandom_range(1));
      id    = $urandom_range(TABLE_WORDS - 1);
      if (pick < 15)
         op = OP_ALLOC;
      else if (pick < 18)
         op = OP_UNUSED;
      else
         op = (pick < 59) ? OP_WAIT : OP_SIGNAL;
      // Most waits and signals land on a live id; the rest are left as random noise.
      if ((op == OP_WAIT || op == OP_SIGNAL) && $urandom_range(99) < 85) begin
         total = gen_user_count + ((level == LEVEL_SYSTEM) ? gen_system_count : 0);
         if (total > 0) begin
            id = $urandom_range(total - 1);
            if (id >= gen_user_count)
               id = SEMS_PER_LEVEL + id - gen_user_count;
         end
      end
      push_request(op, level, id, random_count());
   endtask

   // The stimulus process pauses here until every request is taken and answered.
   task automatic drain_requests();
      while (pending_requests.size() != 0 || start)
         @(negedge clock);
      while (owed_results.size() != 0)
         @(negedge clock);
   endtask

   // Driver: inputs move on the falling edge. A request stays on the ports until the
   // rising edge has seen start high with busy low; the next one may follow at once.
   always @(negedge clock) begin
      sem_request_type rq;
      logic next_start;
      next_start = start;
      if (start && req_taken)
         next_start = 1'b0;
      if (!reset && !next_start && pending_requests.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
         rq = pending_requests.pop_front();
         req_opcode        <= rq.op;
         req_caller_level  <= rq.level;
         req_sem_id        <= rq.id;
         req_initial_count <= rq.init;
         next_start = 1'b1;
      end else if (!next_start) begin
         // Idle cycles carry junk on the payload so that it cannot leak into a result.
         req_opcode        <= 2'($urandom_range(3));
         req_caller_level  <= 1'($urandom_range(1));
         req_sem_id        <= ID_BITS'($urandom_range(TABLE_WORDS - 1));
         req_initial_count <= INIT_BITS'($urandom_range(65535));
      end
      start <= next_start;
   end

   // Monitor: at each rising edge the oldest owed result is checked against a strobe,
   // and a request taken at that edge is run through the predictor.
   always @(posedge clock) begin
      sem_request_type rq;
      sem_result_type want;
      logic moved;
      logic taken;
      moved = 1'b0;
      taken = 1'b0;
      if (!reset) begin
         if (rsp_strobe) begin
            moved = 1'b1;
            if (owed_results.size() == 0) begin
               report_mismatch("result with nothing outstanding, status", rsp_status, 0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_new_id !== want.new_id)
                  report_mismatch("new_id", rsp_new_id, want.new_id);
               if (rsp_must_block !== want.must_block)
                  report_mismatch("must_block", rsp_must_block, want.must_block);
               if (rsp_wake_one !== want.wake_one)
                  report_mismatch("wake_one", rsp_wake_one, want.wake_one);
               case (want.status)
                  STATUS_OK:   grants_seen += (want.must_block || want.wake_one) ? 0 : 1;
                  STATUS_FULL: full_seen++;
                  default:     bad_seen++;
               endcase
               blocks_seen += want.must_block;
               wakes_seen  += want.wake_one;
            end
         end
         if (start && !busy) begin
            moved = 1'b1;
            rq.op    = opcode_type'(req_opcode);
            rq.level = req_caller_level;
            rq.id    = req_sem_id;
            rq.init  = req_initial_count;
            owed_results.push_back(predict_semaphore_op(rq));
            taken = 1'b1;
            requests_taken++;
         end
         // Watchdog on the number of cycles in a row with no transfer on either side.
         if (moved) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
               $display("tb_counting_semaphore_table_unit failed");
               $finish;
            end
         end
      end
      req_taken <= taken;
   end

   initial begin
      int phase;
      int idle_mix [3];
      logic level;
      idle_mix = '{0, 78, 8};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening with the sender never idle. Ids before any allocation are bad,
      // then both halves get live ids loaded with the counter limits and values near zero.
      push_request(OP_WAIT,   1'b0, 0, 0);
      push_request(OP_SIGNAL, LEVEL_SYSTEM, 64, 0);
      push_request(OP_UNUSED, 1'b0, 0, 0);
      push_request(OP_ALLOC,  1'b0, 0, 32767);
      push_request(OP_ALLOC,  1'b0, 127, -32768);
      push_request(OP_ALLOC,  1'b0, 0, 0);
      push_request(OP_ALLOC,  LEVEL_SYSTEM, 0, -1);
      push_request(OP_ALLOC,  LEVEL_SYSTEM, 127, 1);
      // A signal at the top and a wait at the bottom stay put; the wait still blocks.
      push_request(OP_SIGNAL, 1'b0, 0, 0);
      push_request(OP_WAIT,   1'b0, 1, 0);
      push_request(OP_SIGNAL, 1'b0, 1, 0);
      // Walk id 2 across zero in both directions.
      push_request(OP_WAIT,   1'b0, 2, 0);
      push_request(OP_SIGNAL, 1'b0, 2, 0);
      push_request(OP_SIGNAL, 1'b0, 2, 0);
      push_request(OP_WAIT,   1'b0, 2, 0);
      // The system half is closed to user callers; system callers reach both halves.
      push_request(OP_WAIT,   1'b0, 64, 0);
      push_request(OP_WAIT,   LEVEL_SYSTEM, 64, 0);
      push_request(OP_SIGNAL, LEVEL_SYSTEM, 0, 0);
      push_request(OP_SIGNAL, LEVEL_SYSTEM, 65, 0);
      push_request(OP_WAIT,   LEVEL_SYSTEM, 66, 0);
      push_request(OP_SIGNAL, 1'b0, 3, 0);
      push_request(OP_WAIT,   LEVEL_SYSTEM, 127, 0);
      push_request(OP_UNUSED, LEVEL_SYSTEM, 127, -1);
      push_request(OP_ALLOC,  1'b0, 127, 32767);
      drain_requests();

      // Random traffic under each sender idling mix; every phase ends with the sender
      // holding off until all results are back.
      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct = idle_mix[phase];
         repeat (RANDOM_ITEMS) queue_random_request();
         drain_requests();
      end

      // Fill both halves, mixed with other traffic, then knock on the full halves.
      sender_idle_pct = 0;
      while (gen_user_count < SEMS_PER_LEVEL || gen_system_count < SEMS_PER_LEVEL) begin
         if ($urandom_range(3) == 0) begin
            queue_random_request();
         end else begin
            level = (gen_user_count >= SEMS_PER_LEVEL) ? LEVEL_SYSTEM :
                    (gen_system_count >= SEMS_PER_LEVEL) ? 1'b0 : 1'($urandom_range(1));
            push_request(OP_ALLOC, level, $urandom_range(TABLE_WORDS - 1), random_count());
         end
      end
      repeat (4) push_request(OP_ALLOC, 1'b0, 0, random_count());
      repeat (4) push_request(OP_ALLOC, LEVEL_SYSTEM, 0, random_count());
      drain_requests();

      // Full table: ids up to 127 are all live for system callers now.
      sender_idle_pct = 8;
      repeat (60) queue_random_request();
      drain_requests();
      repeat (8) @(posedge clock);

      $display("Ran %0d requests: %0d plain successes, %0d refused for a full half,",
               requests_taken, grants_seen, full_seen);
      $display("%0d rejected for a bad id or opcode, %0d waits that blocked, %0d wakeups.",
               bad_seen, blocks_seen, wakes_seen);
      if (mismatch_count == 0) begin
         $display("tb_counting_semaphore_table_unit passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("tb_counting_semaphore_table_unit failed");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/csem_pkg.sv
hdl/csem_ram.sv
hdl/csem_queue.sv
hdl/csem_front.sv
hdl/csem_back.sv
hdl/counting_semaphore_table_unit.sv
dv/tb_counting_semaphore_table_unit.sv
